// ----- design/aidr_pkg.sv -----
package aidr_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int POS_W     = 6;
    localparam int KIND_W    = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND  = 2'd0,
        KIND_INSERT  = 2'd1,
        KIND_DELETE  = 2'd2,
        KIND_REVERSE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_REV_STEP,
        CELL_REV_LAST
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

    typedef struct packed {
        logic               accepted;
        logic               take;
        logic [CAP_W-1:0]   count;
    } res_t;

    typedef enum logic {
        ST_IDLE,
        ST_REV
    } state_t;

endpackage

// ----- design/aidr_cell.sv -----
module aidr_cell
    import aidr_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 7
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [PW-1:0]     pos,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [DATA_W-1:0] next_data,
    input  logic [DATA_W-1:0] push_data,
    output logic [DATA_W-1:0] main_data,
    output logic [DATA_W-1:0] stack_data
);

    logic [DATA_W-1:0] main_reg;
    logic [DATA_W-1:0] main_next;
    logic [DATA_W-1:0] stack_reg;
    logic [DATA_W-1:0] stack_next;

    always_comb
    begin
        main_next  = main_reg;
        stack_next = stack_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (IDX > int'(pos))
                begin
                    main_next = prev_data;
                end
                else if (IDX == int'(pos))
                begin
                    main_next = ctrl.value;
                end
            end
            CELL_DELETE:
            begin
                if (IDX >= int'(pos))
                begin
                    main_next = next_data;
                end
            end
            CELL_REV_STEP:
            begin
                // pop toward index 0, push onto the stack row
                main_next  = next_data;
                stack_next = push_data;
            end
            CELL_REV_LAST:
            begin
                // the stack row now holds the reversed order: copy it back
                main_next  = push_data;
                stack_next = push_data;
            end
            default:
            begin
                main_next = main_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        main_reg  <= main_next;
        stack_reg <= stack_next;
    end

    assign main_data  = main_reg;
    assign stack_data = stack_reg;

endmodule

// ----- design/aidr_ctrl.sv -----
module aidr_ctrl
    import aidr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [KIND_W-1:0] kind,
    input  logic [POS_W-1:0]  position,
    input  logic [DATA_W-1:0] value,
    input  logic [CAP_W-1:0]  cap,
    output logic              busy,
    output cell_ctrl_t        cell_ctrl,
    output logic [CNT_W-1:0]  cell_pos,
    output res_t              res
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  rev_left_reg;
    logic [CNT_W-1:0]  rev_left_next;

    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cap_x;
    logic [CMP_W-1:0]  cap_eff;
    logic              app_ok;
    logic              ins_ok;
    logic              del_ok;
    logic              rev_start;

    assign cnt_x   = CMP_W'(count_reg);
    assign pos_x   = CMP_W'(position);
    assign cap_x   = CMP_W'(cap);
    assign cap_eff = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;
    assign app_ok  = cnt_x < cap_eff;
    assign ins_ok  = (pos_x <= cnt_x) && (cnt_x < cap_eff);
    assign del_ok  = pos_x < cnt_x;
    assign rev_start = take && (kind_t'(kind) == KIND_REVERSE) && (count_reg > CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rev_start)
                begin
                    state_next = ST_REV;
                end
            end
            ST_REV:
            begin
                if (rev_left_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = value;
        cell_pos        = pos_x[CNT_W-1:0];
        count_next      = count_reg;
        rev_left_next   = rev_left_reg;
        res.accepted    = 1'b0;
        res.take        = 1'b0;
        busy            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (kind_t'(kind))
                        KIND_APPEND:
                        begin
                            if (app_ok)
                            begin
                                cell_ctrl.op = CELL_INSERT;
                                cell_pos     = count_reg;
                                count_next   = count_reg + CNT_W'(1);
                                res.accepted = 1'b1;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                cell_ctrl.op = CELL_INSERT;
                                count_next   = count_reg + CNT_W'(1);
                                res.accepted = 1'b1;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (del_ok)
                            begin
                                cell_ctrl.op = CELL_DELETE;
                                count_next   = count_reg - CNT_W'(1);
                                res.accepted = 1'b1;
                                res.take     = 1'b1;
                            end
                        end
                        KIND_REVERSE:
                        begin
                            res.accepted  = 1'b1;
                            rev_left_next = count_reg;
                        end
                        default:
                        begin
                            res.accepted = 1'b0;
                        end
                    endcase
                end
            end
            ST_REV:
            begin
                busy          = 1'b1;
                rev_left_next = rev_left_reg - CNT_W'(1);
                if (rev_left_reg == CNT_W'(1))
                begin
                    cell_ctrl.op = CELL_REV_LAST;
                end
                else
                begin
                    cell_ctrl.op = CELL_REV_STEP;
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        res.count = CAP_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rev_left_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rev_left_reg <= rev_left_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds depth");

    a_rev_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV) |-> (rev_left_reg != '0))
        else $error("reverse running with no steps left");

    a_rev_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV && rev_left_reg == CNT_W'(1)) |=> (state_reg == ST_IDLE))
        else $error("reverse did not finish");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REV) |=> (count_reg == $past(count_reg)))
        else $error("count moved during reverse");
`endif

endmodule

// ----- design/array_insert_delete_reverse_top.sv -----
// Packed array of DEPTH signed 32-bit entries with append, insert, delete
// and reverse. Each entry lives in one cell of a row; insert and delete shift
// every cell at or above the position from its neighbor, and after an append,
// insert or delete the next beat can be accepted right behind it. Reverse of n
// entries (n > 1) pops the row through a second stack register in each cell,
// one step per cycle, and holds the input stalled until the reverse is done;
// reverse of 0 or 1 entries does not stall the input. The result beat for
// every request is presented the cycle after acceptance and sits in an output
// register, so a result that is taken does not block the next request; only a
// result held there by out_stall does. capacity is written through cfg_we and
// cfg_data; the user writes it only while the block is idle, as the block
// itself does not enforce this. A value above DEPTH acts as DEPTH, and
// lowering it below the current count keeps the entries and rejects further
// appends and inserts. removed_value is 0 for all but an accepted delete.
module array_insert_delete_reverse_top
    import aidr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] removed_value,
    output logic                     accepted,
    output logic [CAP_W-1:0]         count_after
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [CAP_W-1:0]  cap_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] removed_reg;
    logic              accepted_reg;
    logic [CAP_W-1:0]  count_reg;

    logic              take;
    logic              busy;
    cell_ctrl_t        cell_ctrl;
    logic [CNT_W-1:0]  cell_pos;
    res_t              res;
    logic [DATA_W-1:0] removed_sel;

    logic [DATA_W-1:0] main_q  [DEPTH];
    logic [DATA_W-1:0] stack_q [DEPTH];

    // Stall new requests while a reverse runs or the result slot is full and held by out_stall.
    assign in_stall = busy || (out_valid_reg && out_stall);
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    aidr_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .kind      (kind),
        .position  (position),
        .value     (DATA_W'(value)),
        .cap       (cap_reg),
        .busy      (busy),
        .cell_ctrl (cell_ctrl),
        .cell_pos  (cell_pos),
        .res       (res)
    );

    // The row: each cell sees its lower and upper neighbor for shifts, and the
    // stack value below it for reverse. Cell 0 pushes its own entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;
        logic [DATA_W-1:0] push_d;

        if (i == 0)
        begin : g_first
            assign prev_d = main_q[0];
            assign push_d = main_q[0];
        end
        else
        begin : g_mid
            assign prev_d = main_q[i-1];
            assign push_d = stack_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = main_q[i];
        end
        else
        begin : g_up
            assign next_d = main_q[i+1];
        end

        aidr_cell #(
            .IDX (i),
            .PW  (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos        (cell_pos),
            .prev_data  (prev_d),
            .next_data  (next_d),
            .push_data  (push_d),
            .main_data  (main_q[i]),
            .stack_data (stack_q[i])
        );
    end

    // Pick the entry leaving on delete; only meaningful when the delete is taken.
    assign removed_sel = res.take ? main_q[cell_pos[IDX_W-1:0]] : '0;

    // Advance the result slot: load on accept, drop once the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            removed_reg  <= removed_sel;
            accepted_reg <= res.accepted;
            count_reg    <= res.count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign accepted      = accepted_reg;
    assign count_after   = count_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !take)
        else $error("request accepted during reverse");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("accepted request left no result");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(count_reg))
        else $error("stalled result changed");
`endif

endmodule
